FILE: design/wgm_pkg.sv
package wgm_pkg;

    // Pattern bytes with a meaning of their own
    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;
    localparam logic [7:0] END_CHAR  = 8'h00;

    // Pattern storage is fixed at two 64-bit words
    localparam int PATTERN_BYTES = 16;
    localparam int WORD_W        = 64;
    localparam int LENGTH_W      = 5;
    localparam int CFG_INDEX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    // Signals rippling from one position cell to the next
    typedef struct packed {
        logic close0;  // star closure of the stored positions
        logic adv;     // character consumed at the previous position
        logic close1;  // star closure after the advance
    } chain_t;

    // Per-item control shared by all cells
    typedef struct packed {
        logic has_char;  // item carries a character
        logic load;      // accepted item with a character
        logic restart;   // accepted item that ends the name
    } step_t;

endpackage

FILE: design/wildcard_glob_matcher_core.sv
// Glob matcher: streams the characters of one name and reports whether the
// whole name matches the configured pattern ('*' any run, '?' one char).
// Input channel s_*: one character per item (s_has_char), s_last ends the
// name; an item with s_has_char low and s_last high ends it with no char.
// Result channel m_*: one item per name, m_matched, given for the item that
// carries s_last, in the cycle after it is accepted.
// Throughput is one item per cycle: a row of MAX_PATTERN+1 position cells
// holds the live pattern positions and all of them step together, with star
// closure rippling along the row within the cycle.
// The result sits in an output register; a new item is taken whenever that
// register is empty or being drained, so a stalled receiver holds off the
// input only while a result is waiting.
// Configuration: cfg_index 0/1 write pattern bytes 0-7 / 8-15 (byte 0 in bits
// 7:0), index 2 writes the pattern length; write only while idle.
// Reset (aresetn low, synchronous) clears the pattern registers, empties the
// output register and leaves only position zero live.
module wildcard_glob_matcher_core #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wgm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wgm_pkg::WORD_W-1:0]       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_ch,
    input  logic                             s_has_char,
    input  logic                             s_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_matched
);

    localparam int CELLS = MAX_PATTERN + 1;
    localparam int LEN_W = $clog2(CELLS);

    logic [wgm_pkg::WORD_W-1:0]   pat_low_reg;
    logic [wgm_pkg::WORD_W-1:0]   pat_high_reg;
    logic [wgm_pkg::LENGTH_W-1:0] pat_len_reg;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic                         m_matched_reg;
    logic                         m_matched_next;

    logic [7:0]       pat_bytes [wgm_pkg::PATTERN_BYTES];
    logic [LEN_W-1:0] len_cap;
    logic [LEN_W-1:0] eff_len;
    logic [CELLS-1:0] cell_en;
    logic [CELLS-1:0] view_vec;
    wgm_pkg::chain_t  chain [CELLS+1];
    wgm_pkg::step_t   step;
    logic             s_accept;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                wgm_pkg::REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                wgm_pkg::REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                wgm_pkg::REG_PATTERN_LEN:  pat_len_reg  <= cfg_data[wgm_pkg::LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Pattern bytes and effective length (capped, cut at first zero byte)
    always_comb begin
        for (int i = 0; i < wgm_pkg::PATTERN_BYTES; i++) begin
            if (i < 8) begin
                pat_bytes[i] = pat_low_reg[8*i +: 8];
            end else begin
                pat_bytes[i] = pat_high_reg[8*(i-8) +: 8];
            end
        end
    end

    always_comb begin
        if (pat_len_reg > wgm_pkg::LENGTH_W'(MAX_PATTERN)) begin
            len_cap = LEN_W'(MAX_PATTERN);
        end else begin
            len_cap = LEN_W'(pat_len_reg);
        end
        eff_len = len_cap;
        for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
            if ((LEN_W'(i) < len_cap) && (pat_bytes[i] == wgm_pkg::END_CHAR)) begin
                eff_len = LEN_W'(i);
            end
        end
        for (int i = 0; i < CELLS; i++) begin
            cell_en[i] = (LEN_W'(i) < eff_len);
        end
    end

    // Handshake: take an item whenever the result register can move
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign step.has_char = s_has_char;
    assign step.load     = s_accept && s_has_char;
    assign step.restart  = s_accept && s_last;

    // Row of position cells
    assign chain[0] = '0;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        logic [7:0] cell_byte;
        if (g < MAX_PATTERN) begin : g_byte
            assign cell_byte = pat_bytes[g];
        end else begin : g_end
            assign cell_byte = wgm_pkg::END_CHAR;
        end
        wgm_cell #(
            .RESET_LIVE (g == 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .pat_byte  (cell_byte),
            .en        (cell_en[g]),
            .ch        (s_ch),
            .step      (step),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .view      (view_vec[g])
        );
    end

    // Output register
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_matched_next = m_matched_reg;
        if (s_accept && s_last) begin
            m_valid_next   = 1'b1;
            m_matched_next = view_vec[eff_len];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_matched_reg <= m_matched_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

    // Checks
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> m_valid)
        else $error("ending item gave no result");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> (view_vec[0] && !s_has_char ||
                                            s_has_char || !s_valid || !s_ready ||
                                            g_cell[0].u_cell.view))
        else $error("position zero not live after name end");

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last && !m_valid) |=> !m_valid)
        else $error("result without ending item");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_matched) && m_valid))
        else $error("waiting result changed");

endmodule

FILE: design/wgm_cell.sv
module wgm_cell #(
    parameter logic RESET_LIVE = 1'b0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     pat_byte,
    input  logic           en,
    input  logic [7:0]     ch,
    input  wgm_pkg::step_t step,
    input  wgm_pkg::chain_t chain_in,
    output wgm_pkg::chain_t chain_out,
    output logic           view
);

    logic live_reg;
    logic live_next;
    logic is_star;
    logic char_ok;
    logic closed0;
    logic star_hit0;
    logic nv;
    logic closed1;

    // Pattern byte decode for this position
    assign is_star = en && (pat_byte == wgm_pkg::STAR_CHAR);
    assign char_ok = en && !is_star &&
                     ((pat_byte == wgm_pkg::ANY_CHAR) || (pat_byte == ch));

    // Closure, advance, closure again
    assign closed0   = live_reg | chain_in.close0;
    assign star_hit0 = closed0 & is_star;
    assign nv        = star_hit0 | chain_in.adv;
    assign closed1   = nv | chain_in.close1;

    assign chain_out.close0 = star_hit0;
    assign chain_out.adv    = closed0 & char_ok;
    assign chain_out.close1 = closed1 & is_star;

    // Position as seen by the result of this item
    assign view = step.has_char ? closed1 : closed0;

    always_comb begin
        live_next = live_reg;
        if (step.restart) begin
            live_next = RESET_LIVE;
        end else if (step.load) begin
            live_next = closed1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= RESET_LIVE;
        end else begin
            live_reg <= live_next;
        end
    end

endmodule

FILE: dv/wildcard_glob_matcher_core_tb.sv
module wildcard_glob_matcher_core_tb;

    localparam int MAX_PATTERN    = 16;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    // index that maps to no register
    localparam logic [wgm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [7:0] CH_A = "a";
    localparam logic [7:0] CH_B = "b";
    localparam logic [7:0] CH_C = "c";
    localparam logic [7:0] CH_Q = "q";
    localparam logic [7:0] CH_X = "x";
    localparam logic [7:0] CH_Z = "z";

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

    // Tracks the pattern and the live positions, predicts one verdict per name
    class glob_scoreboard;
        typedef logic [wgm_pkg::PATTERN_BYTES:0] live_t;

        logic [wgm_pkg::WORD_W-1:0]   pat_low;
        logic [wgm_pkg::WORD_W-1:0]   pat_high;
        logic [wgm_pkg::LENGTH_W-1:0] pat_len;
        live_t                        live;
        bit                           verdicts[$];
        int                           mismatches;

        function new();
            pat_low    = '0;
            pat_high   = '0;
            pat_len    = '0;
            live       = {{wgm_pkg::PATTERN_BYTES{1'b0}}, 1'b1};
            mismatches = 0;
        endfunction

        function void apply_reg(logic [wgm_pkg::CFG_INDEX_W-1:0] idx,
                                logic [wgm_pkg::WORD_W-1:0] data);
            case (idx)
                wgm_pkg::REG_PATTERN_LOW:  pat_low  = data;
                wgm_pkg::REG_PATTERN_HIGH: pat_high = data;
                wgm_pkg::REG_PATTERN_LEN:  pat_len  = data[wgm_pkg::LENGTH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern_byte(int i);
            return (i < 8) ? pat_low[i*8 +: 8] : pat_high[(i-8)*8 +: 8];
        endfunction

        // bytes in use: length capped, cut at the first zero byte
        function int live_limit();
            int n;
            n = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
            for (int i = 0; i < n; i++)
                if (pattern_byte(i) == wgm_pkg::END_CHAR) return i;
            return n;
        endfunction

        // a live star also makes the next position live, rippling upward
        function live_t star_closure(live_t v, int n);
            for (int i = 0; i < n; i++)
                if (v[i] && pattern_byte(i) == wgm_pkg::STAR_CHAR) v[i+1] = 1'b1;
            return v;
        endfunction

        function live_t consume_char(live_t v, int n, logic [7:0] c);
            live_t nv;
            nv = '0;
            for (int i = 0; i < n; i++) begin
                if (v[i]) begin
                    if (pattern_byte(i) == wgm_pkg::STAR_CHAR)
                        nv[i] = 1'b1;
                    else if (pattern_byte(i) == wgm_pkg::ANY_CHAR || pattern_byte(i) == c)
                        nv[i+1] = 1'b1;
                end
            end
            return nv;
        endfunction

        function void take_item(logic [7:0] c, logic has_char, logic last);
            int n;
            live_t v;
            n = live_limit();
            v = star_closure(live, n);
            if (has_char) begin
                v    = star_closure(consume_char(v, n, c), n);
                live = v;
            end
            if (last) begin
                verdicts.push_back(v[n]);
                live = {{wgm_pkg::PATTERN_BYTES{1'b0}}, 1'b1};
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_verdict(logic got);
            bit want;
            if (verdicts.size() == 0) begin
                report($sformatf("result matched=%b with no name pending", got));
                return;
            end
            want = verdicts.pop_front();
            if (got !== want)
                report($sformatf("matched=%b, expected %b", got, want));
        endtask
    endclass

    logic                              aclk       = 1'b0;
    logic                              aresetn    = 1'b0;
    logic                              cfg_valid  = 1'b0;
    logic                              cfg_ready;
    logic [wgm_pkg::CFG_INDEX_W-1:0]   cfg_index  = '0;
    logic [wgm_pkg::WORD_W-1:0]        cfg_data   = '0;
    logic                              s_valid    = 1'b0;
    logic                              s_ready;
    logic [7:0]                        s_ch       = '0;
    logic                              s_has_char = 1'b0;
    logic                              s_last     = 1'b0;
    logic                              m_valid;
    logic                              m_ready    = 1'b0;
    logic                              m_matched;

    glob_scoreboard sb = new();

    int burst_left   = 0;
    bit no_gaps      = 1'b0;
    int sent_items   = 0;
    bit long_hold    = 1'b0;
    int quiet_cycles = 0;

    wildcard_glob_matcher_core #(
        .MAX_PATTERN(MAX_PATTERN)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_ch      (s_ch),
        .s_has_char(s_has_char),
        .s_last    (s_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_matched (m_matched)
    );

    always #4 aclk = ~aclk;

    // Sample every handshake at the edge it completes on; watchdog on silence
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.take_item(s_ch, s_has_char, s_last);
            if (m_valid && m_ready) sb.check_verdict(m_matched);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result side: random stall patterns, each used for a random run before a new one is drawn
    initial begin : receiver
        rx_mode_t mode;
        int       left;
        int       cyc;
        mode = RX_ALWAYS;
        left = 0;
        cyc  = 0;
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
            end
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(16, 96);
            end
            left--;
            cyc++;
            case (mode)
                RX_ALWAYS:   m_ready <= 1'b1;
                RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                RX_SLOW:     m_ready <= ($urandom_range(0, 7) == 0);
                default:     m_ready <= (cyc % 3 == 0);
            endcase
            @(posedge aclk);
        end
    end

    // Offer one item, with a random gap at the start of each burst
    task automatic push_item(logic [7:0] c, logic has_char, logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_ch       <= c;
        s_has_char <= has_char;
        s_last     <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (has_char || last) sent_items++;
    endtask

    // Stop sending and wait until every verdict is back and the block is quiet
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [wgm_pkg::CFG_INDEX_W-1:0] idx,
                             logic [wgm_pkg::WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 7))
            0, 1, 2: return CH_A;
            3, 4:    return CH_B;
            5:       return CH_C;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random pattern, mostly over a small alphabet, registers written in rotating order
    task automatic load_random_pattern(int phase);
        logic [wgm_pkg::WORD_W-1:0]   lo, hi, len_word;
        logic [7:0]                   b;
        logic [wgm_pkg::LENGTH_W-1:0] len;
        for (int i = 0; i < wgm_pkg::PATTERN_BYTES; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: b = CH_A;
                3:       b = CH_B;
                4, 5:    b = wgm_pkg::STAR_CHAR;
                6, 7:    b = wgm_pkg::ANY_CHAR;
                8:       b = 8'($urandom_range(0, 255));
                default: b = rand_char();
            endcase
            if (i < 8) lo[i*8 +: 8] = b;
            else hi[(i-8)*8 +: 8] = b;
        end
        if ($urandom_range(0, 7) == 0) lo = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) hi = {$urandom, $urandom};
        // early terminator somewhere in the pattern
        if ($urandom_range(0, 5) == 0) begin
            b = 8'($urandom_range(0, wgm_pkg::PATTERN_BYTES - 1));
            if (b < 8) lo[b*8 +: 8] = wgm_pkg::END_CHAR;
            else hi[(b-8)*8 +: 8] = wgm_pkg::END_CHAR;
        end
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = wgm_pkg::LENGTH_W'(wgm_pkg::PATTERN_BYTES);
            2:       len = wgm_pkg::LENGTH_W'($urandom_range(wgm_pkg::PATTERN_BYTES + 1, 31));
            3:       len = wgm_pkg::LENGTH_W'($urandom_range(9, wgm_pkg::PATTERN_BYTES));
            default: len = wgm_pkg::LENGTH_W'($urandom_range(1, 8));
        endcase
        len_word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
        len_word[wgm_pkg::LENGTH_W-1:0] = len;
        for (int k = 0; k < 3; k++) begin
            case ((phase + k) % 3)
                0:       write_reg(wgm_pkg::REG_PATTERN_LOW, lo);
                1:       write_reg(wgm_pkg::REG_PATTERN_HIGH, hi);
                default: write_reg(wgm_pkg::REG_PATTERN_LEN, len_word);
            endcase
        end
        cfg_release();
    endtask

    // Name built from the current pattern, broken now and then, with noise items
    task automatic send_name();
        logic [7:0] name[$];
        logic [7:0] b;
        int         n;
        int         pos;
        bit         end_on_char;
        n = sb.live_limit();
        for (int i = 0; i < n; i++) begin
            b = sb.pattern_byte(i);
            if (b == wgm_pkg::STAR_CHAR)
                repeat ($urandom_range(0, 3)) name.push_back(rand_char());
            else if (b == wgm_pkg::ANY_CHAR)
                name.push_back(rand_char());
            else
                name.push_back(b);
        end
        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, name.size());
            case ($urandom_range(0, 2))
                0:       name.insert(pos, rand_char());
                1:       if (pos < name.size()) name.delete(pos);
                default: if (pos < name.size()) name[pos] = rand_char();
            endcase
        end
        end_on_char = ($urandom_range(0, 3) != 0) && (name.size() != 0);
        foreach (name[k]) begin
            if ($urandom_range(0, 9) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(name[k], 1'b1, end_on_char && (k == name.size() - 1));
        end
        if (!end_on_char) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial begin : stimulus
        int phase_items;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pattern out of reset: noise item, empty name, one-char name
        push_item(CH_X, 1'b0, 1'b0);
        push_item(CH_X, 1'b0, 1'b1);
        push_item(CH_X, 1'b1, 1'b1);
        settle();

        // unmapped index, then a terminator inside the pattern
        write_reg(REG_UNUSED, '1);
        write_reg(wgm_pkg::REG_PATTERN_LOW, {40'h0, CH_B, wgm_pkg::END_CHAR, CH_A});
        write_reg(wgm_pkg::REG_PATTERN_LEN, 64'd3);
        cfg_release();
        push_item(CH_A, 1'b1, 1'b1);
        settle();

        // oversized length, last byte in the high word, zero and 0xFF chars
        write_reg(wgm_pkg::REG_PATTERN_LOW, {8{wgm_pkg::STAR_CHAR}});
        write_reg(wgm_pkg::REG_PATTERN_HIGH, {CH_Z, {7{wgm_pkg::STAR_CHAR}}});
        write_reg(wgm_pkg::REG_PATTERN_LEN, 64'd20);
        cfg_release();
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(CH_Z, 1'b1, 1'b1);
        settle();

        // length change in the middle of a name keeps the live positions
        write_reg(wgm_pkg::REG_PATTERN_LOW, {48'h0, CH_B, CH_A});
        write_reg(wgm_pkg::REG_PATTERN_LEN, 64'd2);
        cfg_release();
        push_item(CH_A, 1'b1, 1'b0);
        settle();
        write_reg(wgm_pkg::REG_PATTERN_LEN, 64'd1);
        cfg_release();
        push_item(CH_X, 1'b0, 1'b1);
        settle();

        // literal, star and any-char together
        write_reg(wgm_pkg::REG_PATTERN_LOW,
                  {32'h0, wgm_pkg::ANY_CHAR, CH_B, wgm_pkg::STAR_CHAR, CH_A});
        write_reg(wgm_pkg::REG_PATTERN_LEN, 64'd4);
        cfg_release();
        push_item(CH_A, 1'b1, 1'b0);
        push_item(CH_X, 1'b1, 1'b0);
        push_item(CH_X, 1'b1, 1'b0);
        push_item(CH_B, 1'b1, 1'b0);
        push_item(CH_Q, 1'b1, 1'b1);
        push_item(CH_A, 1'b1, 1'b0);
        push_item(CH_B, 1'b1, 1'b0);
        push_item(CH_X, 1'b0, 1'b1);

        // random phases, one pattern each
        sent_items = 0;
        for (int phase = 0; sent_items < RANDOM_ITEMS; phase++) begin
            settle();
            load_random_pattern(phase);
            no_gaps = (phase % 5 == 4);
            if (phase == 3) long_hold = 1'b1;
            phase_items = sent_items + $urandom_range(60, 140);
            while (sent_items < phase_items) begin
                send_name();
                if ($urandom_range(0, 19) == 0) settle();
            end
        end

        settle();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d verdicts never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
